// ===== sv/erw_pkg.sv =====
// Package for the echo retransmit window: sizes, operation and status codes,
// register indexes and the cell control/status structs. No dependencies.
package erw_pkg;

    localparam int DEPTH = 8;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_TRACK = 2'd0;
    localparam logic [1:0] OP_REPLY = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [3:0] ST_TRACKED   = 4'd0;
    localparam logic [3:0] ST_FULL      = 4'd1;
    localparam logic [3:0] ST_ACKED     = 4'd2;
    localparam logic [3:0] ST_CORRUPT   = 4'd3;
    localparam logic [3:0] ST_FOREIGN   = 4'd4;
    localparam logic [3:0] ST_UNMATCHED = 4'd5;
    localparam logic [3:0] ST_NOT_ECHO  = 4'd6;
    localparam logic [3:0] ST_RESEND    = 4'd7;
    localparam logic [3:0] ST_IDLE      = 4'd8;

    localparam logic REG_TIMEOUT   = 1'b0;
    localparam logic REG_OWN_IDENT = 1'b1;

    typedef struct packed {
        logic write;
        logic set_acked;
        logic clear_busy;
        logic refresh;
    } cell_ctrl_t;

    typedef struct packed {
        logic        busy;
        logic        acked;
        logic        hit;
        logic        expired;
        logic [15:0] ident;
        logic [15:0] sequence_no;
        logic [31:0] tag;
    } cell_status_t;

endpackage

// ===== sv/erw_cell.sv =====
// One window slot: stores an outstanding request and compares it locally
// against the broadcast reply key and the current time. Uses erw_pkg.
module erw_cell
    import erw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cell_ctrl_t   ctrl,
    input  logic [15:0]  wr_ident,
    input  logic [15:0]  wr_sequence,
    input  logic [31:0]  wr_tag,
    input  logic [31:0]  new_deadline,
    input  logic [15:0]  key_ident,
    input  logic [15:0]  key_sequence,
    input  logic [31:0]  key_tag,
    input  logic [31:0]  time_now,
    output cell_status_t st
);

    logic        busy_reg;
    logic        acked_reg;
    logic [15:0] ident_reg;
    logic [15:0] sequence_reg;
    logic [31:0] tag_reg;
    logic [31:0] deadline_reg;
    logic [31:0] age;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            acked_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.write)
            begin
                busy_reg  <= 1'b1;
                acked_reg <= 1'b0;
            end
            else
            begin
                if (ctrl.set_acked)
                    acked_reg <= 1'b1;
                if (ctrl.clear_busy)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.write)
        begin
            ident_reg    <= wr_ident;
            sequence_reg <= wr_sequence;
            tag_reg      <= wr_tag;
        end
        if (ctrl.write || ctrl.refresh)
            deadline_reg <= new_deadline;
    end

    // serial-number order: expired when now - deadline is positive
    assign age = time_now - deadline_reg;

    assign st.busy        = busy_reg;
    assign st.acked       = acked_reg;
    assign st.hit         = (ident_reg == key_ident) && (sequence_reg == key_sequence)
                            && (tag_reg == key_tag);
    assign st.expired     = (age != 32'd0) && !age[31];
    assign st.ident       = ident_reg;
    assign st.sequence_no = sequence_reg;
    assign st.tag         = tag_reg;

endmodule

// ===== sv/echo_retransmit_window_core.sv =====
// Echo retransmit window top level: row of slot cells and the scan sequencer.
// Depends on erw_pkg and erw_cell.
//
// Use: raise start with operation and the request/reply fields while busy is
// low; the item transfers on that edge. Results appear one per cycle on the
// result ports, marked by result_valid for one cycle; last marks the final
// result of an item. The receiver cannot stall, so results are never held.
// Track, rejected replies and unused operations: one result in the next
// cycle, block ready again at once.
// Matched reply: scan one slot per cycle up to the hit at position i, then a
// slide freeing n acknowledged tail slots one per cycle. Unmatched reply:
// a scan over the occupied slots, then one result.
// Tick: one slot per cycle over the occupied slots, results trail the scan
// by one find.
// The per-cycle figure is set by the slot mux read by the sequencer.
// cfg_write writes register cfg_index (0 timeout, 1 own ident) at once;
// write only while idle. Reset empties the window, time to zero, timeout 2.
module echo_retransmit_window_core
    import erw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [15:0] ident,
    input  logic [15:0] sequence_req,
    input  logic [31:0] payload_tag,
    input  logic        reply_intact,
    input  logic        reply_is_echo,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [3:0]  status,
    output logic [2:0]  entry_index,
    output logic [15:0] out_ident,
    output logic [15:0] out_sequence,
    output logic [31:0] out_tag,
    output logic [3:0]  freed_count,
    output logic        last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_FREE  = 2'd2;
    localparam logic [1:0] S_TICK  = 2'd3;

    logic [1:0]       state_reg;
    logic [7:0]       timeout_reg;
    logic [15:0]      own_ident_reg;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [31:0]      time_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] hit_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_slot_reg;
    logic [15:0]      key_ident_reg;
    logic [15:0]      key_sequence_reg;
    logic [31:0]      key_tag_reg;

    logic             rv_reg;
    logic [3:0]       status_reg;
    logic [2:0]       index_reg;
    logic [15:0]      oid_reg;
    logic [15:0]      oseq_reg;
    logic [31:0]      otag_reg;
    logic [3:0]       freed_reg;
    logic             last_reg;

    cell_ctrl_t       ctrl [DEPTH];
    cell_status_t     cst  [DEPTH];
    logic             accept;
    logic             track_ok;
    logic             in_range;
    logic [IDX_W-1:0] slot;
    logic [31:0]      new_deadline;
    cell_status_t     cur;
    cell_status_t     pend_st;
    cell_status_t     hit_st;

    assign accept       = start && (state_reg == S_IDLE);
    assign busy         = (state_reg != S_IDLE);
    assign track_ok     = accept && (operation == OP_TRACK) && (occ_reg < CNT_W'(DEPTH));
    assign in_range     = (cnt_reg < occ_reg);
    assign slot         = tail_reg + cnt_reg[IDX_W-1:0];
    assign new_deadline = time_reg + {24'd0, timeout_reg};
    assign cur          = cst[slot];
    assign pend_st      = cst[pend_slot_reg];
    assign hit_st       = cst[hit_reg];

    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            ctrl[k] = '0;
            ctrl[k].write = track_ok && (head_reg == IDX_W'(k));
            if (slot == IDX_W'(k) && in_range)
            begin
                ctrl[k].set_acked  = (state_reg == S_MATCH) && cur.hit;
                ctrl[k].clear_busy = (state_reg == S_FREE) && cur.acked;
                ctrl[k].refresh    = (state_reg == S_TICK) && cur.busy && !cur.acked
                                     && cur.expired;
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        erw_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl[g]),
            .wr_ident     (ident),
            .wr_sequence  (sequence_req),
            .wr_tag       (payload_tag),
            .new_deadline (new_deadline),
            .key_ident    (key_ident_reg),
            .key_sequence (key_sequence_reg),
            .key_tag      (key_tag_reg),
            .time_now     (time_reg),
            .st           (cst[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= 8'd2;
            own_ident_reg <= 16'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TIMEOUT:   timeout_reg   <= cfg_data[7:0];
                REG_OWN_IDENT: own_ident_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            tail_reg         <= '0;
            occ_reg          <= '0;
            time_reg         <= '0;
            cnt_reg          <= '0;
            hit_reg          <= '0;
            pend_reg         <= 1'b0;
            pend_slot_reg    <= '0;
            key_ident_reg    <= '0;
            key_sequence_reg <= '0;
            key_tag_reg      <= '0;
            rv_reg           <= 1'b0;
            status_reg       <= '0;
            index_reg        <= '0;
            oid_reg          <= '0;
            oseq_reg         <= '0;
            otag_reg         <= '0;
            freed_reg        <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            rv_reg    <= 1'b0;
            index_reg <= '0;
            oid_reg   <= '0;
            oseq_reg  <= '0;
            otag_reg  <= '0;
            freed_reg <= '0;
            last_reg  <= 1'b1;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        key_ident_reg    <= ident;
                        key_sequence_reg <= sequence_req;
                        key_tag_reg      <= payload_tag;
                        cnt_reg          <= '0;
                        pend_reg         <= 1'b0;
                        case (operation)
                            OP_TRACK:
                            begin
                                rv_reg    <= 1'b1;
                                index_reg <= 3'(head_reg);
                                if (track_ok)
                                begin
                                    status_reg <= ST_TRACKED;
                                    oid_reg    <= ident;
                                    oseq_reg   <= sequence_req;
                                    otag_reg   <= payload_tag;
                                    head_reg   <= head_reg + 1'b1;
                                    occ_reg    <= occ_reg + 1'b1;
                                end
                                else
                                    status_reg <= ST_FULL;
                            end
                            OP_REPLY:
                            begin
                                index_reg <= 3'(tail_reg);
                                if (!reply_intact)
                                begin
                                    rv_reg     <= 1'b1;
                                    status_reg <= ST_CORRUPT;
                                end
                                else if (!reply_is_echo)
                                begin
                                    rv_reg     <= 1'b1;
                                    status_reg <= ST_NOT_ECHO;
                                end
                                else if (ident != own_ident_reg)
                                begin
                                    rv_reg     <= 1'b1;
                                    status_reg <= ST_FOREIGN;
                                end
                                else
                                    state_reg <= S_MATCH;
                            end
                            OP_TICK:
                            begin
                                time_reg  <= time_reg + 32'd1;
                                state_reg <= S_TICK;
                            end
                            default:
                            begin
                                rv_reg     <= 1'b1;
                                status_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                S_MATCH:
                begin
                    if (!in_range)
                    begin
                        rv_reg     <= 1'b1;
                        status_reg <= ST_UNMATCHED;
                        index_reg  <= 3'(tail_reg);
                        state_reg  <= S_IDLE;
                    end
                    else if (cur.hit)
                    begin
                        hit_reg   <= slot;
                        cnt_reg   <= '0;
                        state_reg <= S_FREE;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_FREE:
                begin
                    if (in_range && cur.acked)
                        cnt_reg <= cnt_reg + 1'b1;
                    else
                    begin
                        tail_reg   <= slot;
                        occ_reg    <= occ_reg - cnt_reg;
                        rv_reg     <= 1'b1;
                        status_reg <= ST_ACKED;
                        index_reg  <= 3'(hit_reg);
                        oid_reg    <= hit_st.ident;
                        oseq_reg   <= hit_st.sequence_no;
                        otag_reg   <= hit_st.tag;
                        freed_reg  <= 4'(cnt_reg);
                        state_reg  <= S_IDLE;
                    end
                end
                S_TICK:
                begin
                    if (!in_range)
                    begin
                        // flush the held resend as the final one, or report idle
                        rv_reg <= 1'b1;
                        if (pend_reg)
                        begin
                            status_reg <= ST_RESEND;
                            index_reg  <= 3'(pend_slot_reg);
                            oid_reg    <= pend_st.ident;
                            oseq_reg   <= pend_st.sequence_no;
                            otag_reg   <= pend_st.tag;
                        end
                        else
                            status_reg <= ST_IDLE;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        if (cur.busy && !cur.acked && cur.expired)
                        begin
                            if (pend_reg)
                            begin
                                rv_reg     <= 1'b1;
                                status_reg <= ST_RESEND;
                                index_reg  <= 3'(pend_slot_reg);
                                oid_reg    <= pend_st.ident;
                                oseq_reg   <= pend_st.sequence_no;
                                otag_reg   <= pend_st.tag;
                                last_reg   <= 1'b0;
                            end
                            pend_reg      <= 1'b1;
                            pend_slot_reg <= slot;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = rv_reg;
    assign status       = status_reg;
    assign entry_index  = index_reg;
    assign out_ident    = oid_reg;
    assign out_sequence = oseq_reg;
    assign out_tag      = otag_reg;
    assign freed_count  = freed_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("window occupancy beyond depth");

    a_accept_reacts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (result_valid || busy))
        else $error("accepted item produced neither result nor work");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("non-final result with block idle");
`endif

endmodule

// ===== tb/tb_echo_retransmit_window_core.sv =====
// Self-checking testbench for echo_retransmit_window_core: a directed table,
// then random phases, checked against a behavioural window model or typed rows.
// Depends on erw_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_echo_retransmit_window_core;
    import erw_pkg::*;

    typedef struct {
        logic [3:0]  st;
        logic [2:0]  idx;
        logic [15:0] id;
        logic [15:0] sq;
        logic [31:0] tg;
        logic [3:0]  freed;
        logic        lst;
    } win_result_t;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] id;
        logic [15:0] sq;
        logic [31:0] tg;
        logic        intact;
        logic        echo;
        bit          fixed;     // expectation typed in below
        logic [3:0]  fx_st;
        logic [2:0]  fx_idx;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = OP_TRACK;
    logic [15:0] ident = '0;
    logic [15:0] sequence_req = '0;
    logic [31:0] payload_tag = '0;
    logic        reply_intact = 1'b0;
    logic        reply_is_echo = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = REG_TIMEOUT;
    logic [15:0] cfg_data = '0;
    logic        result_valid;
    logic [3:0]  status;
    logic [2:0]  entry_index;
    logic [15:0] out_ident;
    logic [15:0] out_sequence;
    logic [31:0] out_tag;
    logic [3:0]  freed_count;
    logic        last;

    echo_retransmit_window_core u_top (.*);

    always #10 clk = ~clk;

    // window model state
    logic [7:0]  mdl_timeout;
    logic [15:0] mdl_own_ident;
    logic        mdl_busy  [DEPTH];
    logic        mdl_acked [DEPTH];
    logic [15:0] mdl_ident [DEPTH];
    logic [15:0] mdl_seq   [DEPTH];
    logic [31:0] mdl_tag   [DEPTH];
    logic [31:0] mdl_dead  [DEPTH];
    int          mdl_head, mdl_tail, mdl_occ;
    logic [31:0] mdl_now;

    win_result_t expected_results[$];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          resends_seen = 0;
    int          acks_seen = 0;

    function automatic win_result_t mk(logic [3:0] st, int idx, bit with_slot,
                                       int freed, bit lst);
        win_result_t r;
        r.st    = st;
        r.idx   = idx[2:0];
        r.id    = with_slot ? mdl_ident[idx] : '0;
        r.sq    = with_slot ? mdl_seq[idx] : '0;
        r.tg    = with_slot ? mdl_tag[idx] : '0;
        r.freed = freed[3:0];
        r.lst   = lst;
        return r;
    endfunction

    function automatic bit is_expired(logic [31:0] deadline);
        logic [31:0] d;
        d = mdl_now - deadline;
        return d != 0 && !d[31];
    endfunction

    // Work out the results of one accepted item and advance the model.
    task automatic predict_window(input logic [1:0] op, input logic [15:0] id,
                                  input logic [15:0] sq, input logic [31:0] tg,
                                  input logic intact, input logic echo,
                                  output win_result_t res[$]);
        int s, n, hit;
        res = {};
        if (op == OP_TRACK) begin
            if (mdl_occ >= DEPTH)
                res.push_back(mk(ST_FULL, mdl_head, 1'b0, 0, 1'b1));
            else begin
                s = mdl_head;
                mdl_busy[s]  = 1'b1;
                mdl_acked[s] = 1'b0;
                mdl_ident[s] = id;
                mdl_seq[s]   = sq;
                mdl_tag[s]   = tg;
                mdl_dead[s]  = mdl_now + mdl_timeout;
                mdl_head     = (s + 1) % DEPTH;
                mdl_occ++;
                res.push_back(mk(ST_TRACKED, s, 1'b1, 0, 1'b1));
            end
        end
        else if (op == OP_REPLY) begin
            if (!intact)
                res.push_back(mk(ST_CORRUPT, mdl_tail, 1'b0, 0, 1'b1));
            else if (!echo)
                res.push_back(mk(ST_NOT_ECHO, mdl_tail, 1'b0, 0, 1'b1));
            else if (id != mdl_own_ident)
                res.push_back(mk(ST_FOREIGN, mdl_tail, 1'b0, 0, 1'b1));
            else begin
                hit = -1;
                for (int i = 0; i < mdl_occ; i++) begin
                    s = (mdl_tail + i) % DEPTH;
                    if (hit < 0 && mdl_ident[s] == id && mdl_seq[s] == sq && mdl_tag[s] == tg)
                        hit = s;
                end
                if (hit < 0)
                    res.push_back(mk(ST_UNMATCHED, mdl_tail, 1'b0, 0, 1'b1));
                else begin
                    mdl_acked[hit] = 1'b1;
                    n = 0;
                    while (n < mdl_occ && mdl_acked[(mdl_tail + n) % DEPTH]) begin
                        mdl_busy[(mdl_tail + n) % DEPTH] = 1'b0;
                        n++;
                    end
                    mdl_tail = (mdl_tail + n) % DEPTH;
                    mdl_occ -= n;
                    res.push_back(mk(ST_ACKED, hit, 1'b1, n, 1'b1));
                end
            end
        end
        else if (op == OP_TICK) begin
            mdl_now += 1;
            for (int i = 0; i < mdl_occ; i++) begin
                s = (mdl_tail + i) % DEPTH;
                if (mdl_busy[s] && !mdl_acked[s] && is_expired(mdl_dead[s])) begin
                    mdl_dead[s] = mdl_now + mdl_timeout;
                    res.push_back(mk(ST_RESEND, s, 1'b1, 0, 1'b0));
                end
            end
            if (res.size() == 0)
                res.push_back(mk(ST_IDLE, 0, 1'b0, 0, 1'b1));
            else
                res[res.size() - 1].lst = 1'b1;
        end
        else
            res.push_back(mk(ST_IDLE, 0, 1'b0, 0, 1'b1));
    endtask

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
        errors++;
    endtask

    // result monitor: strobe lasts one cycle, sampled mid-cycle
    always @(negedge clk) begin
        win_result_t w;
        if (rst_n && result_valid) begin
            results_seen++;
            if (status == ST_RESEND) resends_seen++;
            if (status == ST_ACKED) acks_seen++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result status", status, 0);
            else begin
                w = expected_results.pop_front();
                if (status !== w.st) report_mismatch("status", status, w.st);
                if (entry_index !== w.idx) report_mismatch("entry_index", entry_index, w.idx);
                if (out_ident !== w.id) report_mismatch("out_ident", out_ident, w.id);
                if (out_sequence !== w.sq) report_mismatch("out_sequence", out_sequence, w.sq);
                if (out_tag !== w.tg) report_mismatch("out_tag", out_tag, w.tg);
                if (freed_count !== w.freed) report_mismatch("freed_count", freed_count, w.freed);
                if (last !== w.lst) report_mismatch("last", last, w.lst);
            end
        end
    end

    // Called at a rising edge; returns at the edge on which the transfer happens.
    task automatic send_item(input stim_row_t row);
        win_result_t res[$];
        start         <= 1'b1;
        operation     <= row.op;
        ident         <= row.id;
        sequence_req  <= row.sq;
        payload_tag   <= row.tg;
        reply_intact  <= row.intact;
        reply_is_echo <= row.echo;
        forever begin
            @(negedge clk);
            if (!busy) break;
            @(posedge clk);
        end
        predict_window(row.op, row.id, row.sq, row.tg, row.intact, row.echo, res);
        if (row.fixed) begin
            res = {};
            res.push_back('{row.fx_st, row.fx_idx, 16'h0, 16'h0, 32'h0, 4'h0, 1'b1});
        end
        foreach (res[i]) expected_results.push_back(res[i]);
        items_sent++;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (2 * DEPTH + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_TIMEOUT) mdl_timeout = value[7:0];
        else mdl_own_ident = value;
        @(posedge clk);
    endtask

    function automatic stim_row_t row_of(logic [1:0] op, logic [15:0] id, logic [15:0] sq,
                                         logic [31:0] tg, logic intact, logic echo);
        stim_row_t r;
        r = '{op, id, sq, tg, intact, echo, 1'b0, 4'h0, 3'h0};
        return r;
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t r;
        int pick, k;
        pick = $urandom_range(0, 99);
        r = row_of(OP_TICK, 16'($urandom), 16'($urandom), 32'($urandom), 1'b1, 1'b1);
        if (pick < 35) begin
            r.op = OP_TRACK;
            if ($urandom_range(0, 3) != 0) r.id = mdl_own_ident;
        end
        else if (pick < 72) begin
            r.op = OP_REPLY;
            if (mdl_occ > 0 && $urandom_range(0, 9) < 8) begin
                k = (mdl_tail + $urandom_range(0, mdl_occ - 1)) % DEPTH;
                r.id = mdl_ident[k];
                r.sq = mdl_seq[k];
                r.tg = mdl_tag[k];
            end
            else begin
                r.intact = $urandom_range(0, 3) != 0;
                r.echo   = $urandom_range(0, 3) != 0;
                if ($urandom_range(0, 1)) r.id = mdl_own_ident;
            end
        end
        else if (pick < 96)
            r.op = OP_TICK;
        else
            r.op = 2'd3;
        return r;
    endfunction

    stim_row_t directed[] = '{
        '{OP_TICK,  16'h0000, 16'h0000, 32'h0, 1'b1, 1'b1, 1'b1, ST_IDLE,      3'd0},
        '{OP_REPLY, 16'h0000, 16'h0000, 32'h0, 1'b0, 1'b1, 1'b1, ST_CORRUPT,   3'd0},
        '{OP_REPLY, 16'h0000, 16'h0000, 32'h0, 1'b1, 1'b0, 1'b1, ST_NOT_ECHO,  3'd0},
        '{OP_REPLY, 16'h0005, 16'h0000, 32'h0, 1'b1, 1'b1, 1'b1, ST_FOREIGN,   3'd0},
        '{OP_REPLY, 16'h0000, 16'h0001, 32'h1, 1'b1, 1'b1, 1'b1, ST_UNMATCHED, 3'd0},
        '{2'd3,     16'hFFFF, 16'hFFFF, '1,    1'b1, 1'b1, 1'b1, ST_IDLE,      3'd0},
        '{OP_TRACK, 16'h0000, 16'h0000, 32'h00000000, 1'b0, 1'b0, 1'b0, 4'h0, 3'd0},
        '{OP_TRACK, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0},
        '{OP_TRACK, 16'hFFFF, 16'h0000, 32'hA5A5A5A5, 1'b0, 1'b1, 1'b0, 4'h0, 3'd0},
        '{OP_TRACK, 16'h0000, 16'h8000, 32'h80000000, 1'b1, 1'b0, 1'b0, 4'h0, 3'd0},
        '{OP_TRACK, 16'h0000, 16'h0001, 32'h00000001, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0},
        '{OP_TRACK, 16'h5A5A, 16'h1234, 32'h5A5A5A5A, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0},
        '{OP_TRACK, 16'h0000, 16'h0001, 32'h00000001, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0},
        '{OP_TRACK, 16'h0000, 16'h7FFF, 32'h7FFFFFFF, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0},
        '{OP_TRACK, 16'h0000, 16'h0002, 32'h2, 1'b1, 1'b1, 1'b1, ST_FULL,      3'd0},
        '{OP_TICK,  16'h0000, 16'h0000, 32'h0, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0},
        '{OP_TICK,  16'h0000, 16'h0000, 32'h0, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0},
        '{OP_TICK,  16'h0000, 16'h0000, 32'h0, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0},
        '{OP_REPLY, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0},
        '{OP_REPLY, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0},
        '{OP_REPLY, 16'h0000, 16'h0000, 32'h00000000, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0},
        // duplicate contents: oldest copy is matched first
        '{OP_REPLY, 16'h0000, 16'h0001, 32'h00000001, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0},
        '{OP_REPLY, 16'h0000, 16'h0001, 32'h00000002, 1'b1, 1'b1, 1'b0, 4'h0, 3'd0}
    };

    initial begin
        #2_000_000;
        $display("timeout: %0d results still awaited", expected_results.size());
        $display("** echo_retransmit_window_core: FAILED **");
        $finish;
    end

    initial begin
        logic [7:0]  phase_timeout[4];
        logic [15:0] phase_ident[4];
        int burst;
        phase_timeout = '{8'd0, 8'd255, 8'd1, 8'd3};
        phase_ident = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
        phase_ident[2] = 16'($urandom);
        phase_ident[3] = 16'($urandom);
        mdl_timeout = 8'd2;
        mdl_own_ident = '0;
        mdl_head = 0;
        mdl_tail = 0;
        mdl_occ = 0;
        mdl_now = '0;
        for (int i = 0; i < DEPTH; i++) begin
            mdl_busy[i] = 1'b0;
            mdl_acked[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_item(directed[i]);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_TIMEOUT, {8'h00, phase_timeout[ph]});
            write_reg(REG_OWN_IDENT, phase_ident[ph]);
            for (int n = 0; n < 90; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 90; b++, n++) send_item(random_row());
                if (n == 45) begin
                    // pause until the window has answered everything
                    start <= 1'b0;
                    while (expected_results.size() != 0) @(posedge clk);
                end
                else if ($urandom_range(0, 3) != 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            wait_drained();
        end

        $display("%0d items sent, %0d results checked (%0d resends, %0d acks),",
                 items_sent, results_seen, resends_seen, acks_seen);
        $display("timeouts 0/1/3/255 and own idents 0/FFFF/random exercised");
        if (errors == 0)
            $display("** echo_retransmit_window_core: PASSED **");
        else
            $display("** echo_retransmit_window_core: FAILED **");
        $finish;
    end

endmodule
